[hw/rtl/phf_pkg.sv]
// ----------------------------------------------------------------------------
// phf_pkg: shared types and constants of the profile hole filler
// Sample codes, status codes, sequencer states and the interface structs
// between the core and its interpolation unit.
// ----------------------------------------------------------------------------
package phf_pkg;

    // Sample and run widths
    localparam int SAMPLE_W = 16;
    localparam int RUN_W    = 6;
    localparam int DEN_W    = RUN_W + 1;
    localparam int QUOT_W   = SAMPLE_W;
    localparam int STEP_W   = $clog2(QUOT_W);

    // Invalid sample marker
    localparam logic [SAMPLE_W-1:0] INVALID_CODE = 16'h8000;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_ORIGINAL  = 2'd0;
    localparam t_status ST_FILLED    = 2'd1;
    localparam t_status ST_NO_ANCHOR = 2'd2;
    localparam t_status ST_OVERFLOW  = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RUN,
        S_TAIL
    } t_state;

    // Core to interpolation unit
    typedef struct packed {
        logic start;
        logic advance;
    } t_interp_ctl;

    // Interpolation unit to core
    typedef struct packed {
        logic ready;
    } t_interp_sts;

endpackage

[hw/rtl/phf_interp.sv]
// ----------------------------------------------------------------------------
// phf_interp: interpolation step unit
// Divides the gap height difference by the gap length once (restoring, one
// quotient bit per cycle), then walks the ramp one sample per advance with
// the same subtract-and-compare unit: q_k = floor(mag * k / den).
// ----------------------------------------------------------------------------
module phf_interp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  phf_pkg::t_interp_ctl          i_ctl,
    input  logic [phf_pkg::QUOT_W-1:0]    i_mag,
    input  logic [phf_pkg::DEN_W-1:0]     i_den,
    output phf_pkg::t_interp_sts          o_sts,
    output logic [phf_pkg::QUOT_W-1:0]    o_quot
);

    logic                          r_busy;
    logic [phf_pkg::STEP_W-1:0]    r_cnt;
    logic [phf_pkg::QUOT_W-1:0]    r_work;   // dividend in, quotient out
    logic [phf_pkg::DEN_W-1:0]     r_rem;    // remainder, below r_den
    logic [phf_pkg::DEN_W-1:0]     r_den;
    logic [phf_pkg::QUOT_W-1:0]    r_acc_q;
    logic [phf_pkg::DEN_W-1:0]     r_acc_r;

    logic [phf_pkg::DEN_W-1:0]     sub_a;
    logic [phf_pkg::DEN_W:0]       sub_d;
    logic                          sub_ge;
    logic [phf_pkg::DEN_W-1:0]     sub_res;

    // Shared subtract-and-compare against the denominator
    always_comb begin
        if (r_busy) begin
            sub_a = {r_rem[phf_pkg::DEN_W-2:0], r_work[phf_pkg::QUOT_W-1]};
        end else begin
            sub_a = r_acc_r + r_rem;
        end
        sub_d   = {1'b0, sub_a} - {1'b0, r_den};
        sub_ge  = ~sub_d[phf_pkg::DEN_W];
        sub_res = sub_ge ? sub_d[phf_pkg::DEN_W-1:0] : sub_a;
    end

    // Control: busy while dividing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= phf_pkg::STEP_W'(phf_pkg::QUOT_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: divide, then step the ramp
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_work <= i_mag;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= sub_res;
            r_work <= {r_work[phf_pkg::QUOT_W-2:0], sub_ge};
            if (r_cnt == '0) begin
                r_acc_q <= {r_work[phf_pkg::QUOT_W-2:0], sub_ge};
                r_acc_r <= sub_res;
            end
        end else if (i_ctl.advance) begin
            r_acc_r <= sub_res;
            r_acc_q <= r_acc_q + r_work + phf_pkg::QUOT_W'(sub_ge);
        end
    end

    assign o_sts.ready = ~r_busy;
    assign o_quot      = r_acc_q;

endmodule

[hw/rtl/profile_hole_filler_core.sv]
// ----------------------------------------------------------------------------
// profile_hole_filler_core: gap filler for profile height samples
// A valid sample with no held run passes through S_TAIL into the output register.
// A run of held samples is emitted from S_RUN; an interpolated run first waits
// in S_DIV for the one 16-step division of the shared divider unit.
// Input is stalled while a division runs or a run or the final sample of an item is emitted.
// Reset (synchronous, active low) clears the line state and drops any result.
// ----------------------------------------------------------------------------
module profile_hole_filler_core #(
    parameter int MAX_HOLE = 63
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [phf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                             i_line_end,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [phf_pkg::SAMPLE_W-1:0] o_value,
    output logic [1:0]                       o_status,
    output logic                             o_end_of_line,
    output logic                             o_last
);

    // Line state
    phf_pkg::t_state                  r_state, n_state;
    logic [phf_pkg::SAMPLE_W-1:0]     r_left, n_left;
    logic                             r_have_left, n_have_left;
    logic [phf_pkg::RUN_W-1:0]        r_pend, n_pend;

    // Item being emitted
    logic [phf_pkg::RUN_W-1:0]        r_cnt, n_cnt;
    logic [phf_pkg::SAMPLE_W-1:0]     r_fill, n_fill;
    phf_pkg::t_status                 r_fill_st, n_fill_st;
    logic                             r_interp, n_interp;
    logic                             r_neg, n_neg;
    logic [phf_pkg::SAMPLE_W-1:0]     r_right, n_right;
    logic                             r_tail, n_tail;
    logic                             r_eol, n_eol;

    // Output register
    logic                             r_out_valid, n_out_valid;
    logic [phf_pkg::SAMPLE_W-1:0]     r_value, n_value;
    phf_pkg::t_status                 r_status, n_status;
    logic                             r_eol_out, n_eol_out;
    logic                             r_last, n_last;

    // Interpolation unit interface
    phf_pkg::t_interp_ctl             interp_ctl;
    phf_pkg::t_interp_sts             interp_sts;
    logic [phf_pkg::QUOT_W-1:0]       interp_quot;
    logic [phf_pkg::QUOT_W-1:0]       interp_mag;
    logic [phf_pkg::DEN_W-1:0]        interp_den;

    logic                             in_acc;
    logic                             out_load;
    logic                             in_invalid;
    logic [phf_pkg::DEN_W-1:0]        run;
    logic [phf_pkg::SAMPLE_W:0]       diff;
    logic [phf_pkg::SAMPLE_W:0]       diff_mag;
    logic [phf_pkg::SAMPLE_W:0]       ramp;
    logic                             run_final;

    assign o_stall  = (r_state != phf_pkg::S_IDLE);
    assign in_acc   = i_valid & ~o_stall;
    assign out_load = ~r_out_valid | ~i_stall;

    // Decode the incoming sample
    always_comb begin
        in_invalid = (i_sample == phf_pkg::INVALID_CODE);
        run        = {1'b0, r_pend} + 1'b1;
        diff       = {i_sample[phf_pkg::SAMPLE_W-1], i_sample}
                   - {r_left[phf_pkg::SAMPLE_W-1], r_left};
        diff_mag   = diff[phf_pkg::SAMPLE_W] ? (~diff + 1'b1) : diff;
        interp_mag = diff_mag[phf_pkg::QUOT_W-1:0];
        interp_den = run;
    end

    // Ramp value: anchor plus or minus the running quotient
    always_comb begin
        if (r_neg) begin
            ramp = {r_fill[phf_pkg::SAMPLE_W-1], r_fill} - {1'b0, interp_quot};
        end else begin
            ramp = {r_fill[phf_pkg::SAMPLE_W-1], r_fill} + {1'b0, interp_quot};
        end
        run_final = (r_cnt == phf_pkg::RUN_W'(1));
    end

    // Sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_have_left = r_have_left;
        n_pend      = r_pend;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_fill_st   = r_fill_st;
        n_interp    = r_interp;
        n_neg       = r_neg;
        n_right     = r_right;
        n_tail      = r_tail;
        n_eol       = r_eol;
        n_out_valid = r_out_valid & i_stall;
        n_value     = r_value;
        n_status    = r_status;
        n_eol_out   = r_eol_out;
        n_last      = r_last;
        interp_ctl  = '0;

        case (r_state)
            phf_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_eol    = i_line_end;
                    n_interp = 1'b0;
                    n_neg    = diff[phf_pkg::SAMPLE_W];
                    n_right  = i_sample;
                    n_cnt    = run[phf_pkg::RUN_W-1:0];
                    n_fill   = r_have_left ? r_left : phf_pkg::INVALID_CODE;
                    n_tail   = 1'b0;
                    if (in_invalid) begin
                        if (i_line_end) begin
                            // Trailing run: flush held samples plus this one
                            n_fill_st = r_have_left ? phf_pkg::ST_FILLED
                                                    : phf_pkg::ST_NO_ANCHOR;
                            n_state   = phf_pkg::S_RUN;
                        end else if (run >= phf_pkg::DEN_W'(MAX_HOLE)) begin
                            // Overflow: emit the run holding the left value
                            n_fill_st = r_have_left ? phf_pkg::ST_OVERFLOW
                                                    : phf_pkg::ST_NO_ANCHOR;
                            n_pend    = '0;
                            n_state   = phf_pkg::S_RUN;
                        end else begin
                            // Hold the sample back
                            n_pend = run[phf_pkg::RUN_W-1:0];
                        end
                    end else begin
                        n_tail    = 1'b1;
                        n_cnt     = r_pend;
                        n_fill_st = phf_pkg::ST_FILLED;
                        if (r_pend == '0) begin
                            n_state = phf_pkg::S_TAIL;
                        end else if (!r_have_left) begin
                            // Leading run takes the first valid value
                            n_fill  = i_sample;
                            n_state = phf_pkg::S_RUN;
                        end else if (r_pend == phf_pkg::RUN_W'(1)) begin
                            // Single gap copies its left neighbor
                            n_state = phf_pkg::S_RUN;
                        end else begin
                            // Longer gap: ramp between neighbors
                            n_interp         = 1'b1;
                            interp_ctl.start = 1'b1;
                            n_state          = phf_pkg::S_DIV;
                        end
                        n_left      = i_sample;
                        n_have_left = 1'b1;
                        n_pend      = '0;
                    end
                    // Line end clears the line state
                    if (i_line_end) begin
                        n_left      = '0;
                        n_have_left = 1'b0;
                        n_pend      = '0;
                    end
                end
            end
            phf_pkg::S_DIV: begin
                if (interp_sts.ready) begin
                    n_state = phf_pkg::S_RUN;
                end
            end
            phf_pkg::S_RUN: begin
                if (out_load) begin
                    n_out_valid        = 1'b1;
                    n_value            = r_interp ? ramp[phf_pkg::SAMPLE_W-1:0] : r_fill;
                    n_status           = r_fill_st;
                    n_last             = run_final & ~r_tail;
                    n_eol_out          = run_final & ~r_tail & r_eol;
                    interp_ctl.advance = r_interp;
                    n_cnt              = r_cnt - 1'b1;
                    if (run_final) begin
                        n_state = r_tail ? phf_pkg::S_TAIL : phf_pkg::S_IDLE;
                    end
                end
            end
            phf_pkg::S_TAIL: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_value     = r_right;
                    n_status    = phf_pkg::ST_ORIGINAL;
                    n_last      = 1'b1;
                    n_eol_out   = r_eol;
                    n_state     = phf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = phf_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= phf_pkg::S_IDLE;
            r_left      <= '0;
            r_have_left <= 1'b0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_have_left <= n_have_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_fill    <= n_fill;
        r_fill_st <= n_fill_st;
        r_interp  <= n_interp;
        r_neg     <= n_neg;
        r_right   <= n_right;
        r_tail    <= n_tail;
        r_eol     <= n_eol;
        r_value   <= n_value;
        r_status  <= n_status;
        r_eol_out <= n_eol_out;
        r_last    <= n_last;
    end

    phf_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (interp_ctl),
        .i_mag   (interp_mag),
        .i_den   (interp_den),
        .o_sts   (interp_sts),
        .o_quot  (interp_quot)
    );

    assign o_valid       = r_out_valid;
    assign o_value       = r_value;
    assign o_status      = r_status;
    assign o_end_of_line = r_eol_out;
    assign o_last        = r_last;

    // Divider is only started when idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        interp_ctl.start |-> interp_sts.ready)
        else $error("interpolation unit started while busy");

    // Held run never reaches the overflow limit
    a_pend_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_pend < phf_pkg::RUN_W'(MAX_HOLE)))
        else $error("held run reached overflow limit");

    // Line end clears the line state
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_line_end) |=> (!r_have_left && r_pend == '0))
        else $error("line state not cleared at line end");

    // Run emission always has samples left
    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == phf_pkg::S_RUN) |-> (r_cnt != '0))
        else $error("run emission with empty count");

endmodule
